@@ rtl/core/hub75_pkg.sv @@
// ----------------------------------------------------------------------------
// hub75_pkg
// shared constants and types for the led panel frame store and scan-out
// ----------------------------------------------------------------------------
package hub75_pkg;

  // panel geometry
  localparam int CHANNEL_COUNT  = 8;
  localparam int ROW_LENGTH     = 192;
  localparam int PANEL_W        = 48;
  localparam int PANEL_H        = 24;
  localparam int QUAD_W         = 24;
  localparam int QUAD_H         = 12;
  localparam int QUAD_SLOTS     = 384;
  localparam int GROUP_SLOTS    = 16;
  localparam int GROUPS_PER_ROW = 6;

  localparam int ADDR_W  = $clog2(ROW_LENGTH);
  localparam int BANK_W  = $clog2(CHANNEL_COUNT);
  localparam int COLOR_W = 3;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_SHIFT = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [5:0] pixel_x;
    logic [4:0] pixel_y;
    logic [2:0] pixel_color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_lines;
    logic [7:0] green_lines;
    logic [7:0] blue_lines;
    logic       row_end;
  } out_item_t;

  // store write target produced by the remap
  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
    logic [ADDR_W-1:0] addr;
  } store_wr_t;

endpackage

@@ rtl/core/hub75_ram.sv @@
// ----------------------------------------------------------------------------
// hub75_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module hub75_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/hub75_remap.sv @@
// ----------------------------------------------------------------------------
// hub75_remap
// maps a pixel coordinate to its shift channel and position
// ----------------------------------------------------------------------------
module hub75_remap import hub75_pkg::*; (
  input  logic [5:0] pixel_x,
  input  logic [4:0] pixel_y,
  output store_wr_t  wr
);

  logic       right_half;
  logic       lower_half;
  logic [4:0] qx;
  logic [3:0] qy;
  logic [1:0] band;
  logic [2:0] gcol;
  logic [1:0] c;
  logic [1:0] r;
  logic [4:0] gidx;
  logic [3:0] inner;
  logic [8:0] gslot;
  logic       hi;
  logic [8:0] gslot_lo;

  always_comb begin
    right_half = (pixel_x >= 6'(QUAD_W));
    lower_half = (pixel_y >= 5'(QUAD_H));
    qx = right_half ? 5'(pixel_x - 6'(QUAD_W)) : pixel_x[4:0];
    qy = lower_half ? 4'(pixel_y - 5'(QUAD_H)) : pixel_y[3:0];
    band = qy[3:2];
    gcol = qx[4:2];
    c    = qx[1:0];
    r    = qy[1:0];

    // serpentine group order: even bands sit one group row further on
    gidx = (band[0] ? 5'd0 : 5'(GROUPS_PER_ROW))
         + (band[1] ? 5'(2 * GROUPS_PER_ROW) : 5'd0)
         + {2'b00, gcol};

    // sub-row 0 and 1 swap, sub-rows 2 and 3 run reversed
    case (r)
      2'd0:    inner = {2'b01, c};
      2'd1:    inner = {2'b00, c};
      default: inner = {r, ~c};
    endcase

    gslot    = {gidx, inner};
    hi       = (gslot >= 9'(ROW_LENGTH));
    gslot_lo = hi ? 9'(gslot - 9'(ROW_LENGTH)) : gslot;

    wr.en   = (pixel_x < 6'(PANEL_W)) && (pixel_y < 5'(PANEL_H));
    wr.bank = {lower_half, right_half, hi};
    wr.addr = gslot_lo[ADDR_W-1:0];
  end

endmodule

@@ rtl/core/hub75_remap_frame_scanout.sv @@
// ----------------------------------------------------------------------------
// hub75_remap_frame_scanout
// frame store and scan-out for a 48x24 static-scan panel, eight channels
// ----------------------------------------------------------------------------
// After reset the block holds busy high while it clears the frame store, one
// position of all eight channel banks per cycle. From then on busy stays low
// and one request is taken in every cycle. A pixel write lands in the store
// in the cycle after its transfer and gives no result; a write outside the
// panel is dropped. A shift request shows its channel bits on out_item with
// out_valid high for exactly one cycle, after the request and bank read
// registers. The receiver cannot stall, so results must be taken when the
// strobe is high. The rate is set by the store: eight banks of 192 entries,
// each with one write and one registered read port per cycle.
// ----------------------------------------------------------------------------
module hub75_remap_frame_scanout import hub75_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // transfer and clearing pass
  logic              accept;
  logic              clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // request register
  logic              s1_valid_r;
  in_item_t          s1_item_r;

  // shift position and result control
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic              out_valid_r;
  logic              row_end_r;

  logic              rd_en;
  logic              wr_hit;
  store_wr_t         wr;

  logic [CHANNEL_COUNT-1:0] bank_we;
  logic [ADDR_W-1:0]        bank_waddr;
  logic [COLOR_W-1:0]       bank_wdata;
  logic [COLOR_W-1:0]       bank_rdata [CHANNEL_COUNT];

  assign accept = start && !busy;
  assign busy   = clr_active_r;

  // clearing pass walks all positions once after reset
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      if (clr_addr_r == ADDR_W'(ROW_LENGTH - 1)) begin
        clr_active_nxt = 1'b0;
        clr_addr_nxt   = '0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  // pixel coordinate to channel bank and position
  hub75_remap u_remap (
    .pixel_x (s1_item_r.pixel_x),
    .pixel_y (s1_item_r.pixel_y),
    .wr      (wr)
  );

  assign rd_en  = s1_valid_r && (s1_item_r.req_type == REQ_SHIFT);
  assign wr_hit = s1_valid_r && (s1_item_r.req_type == REQ_WRITE) && wr.en;

  // write side: clearing pass hits every bank, a pixel write hits one
  always_comb begin
    bank_waddr = clr_active_r ? clr_addr_r : wr.addr;
    bank_wdata = clr_active_r ? '0 : s1_item_r.pixel_color;
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
      bank_we[ch] = clr_active_r || (wr_hit && (wr.bank == BANK_W'(ch)));
    end
  end

  // shift position wraps at the end of the row
  always_comb begin
    pos_nxt = pos_r;
    if (rd_en) begin
      pos_nxt = (pos_r == ADDR_W'(ROW_LENGTH - 1)) ? '0 : pos_r + 1'b1;
    end
  end

  // one bank per shift channel, all read at the shift position
  for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_bank
    hub75_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (ROW_LENGTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr),
      .wdata (bank_wdata),
      .raddr (pos_r),
      .rdata (bank_rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      s1_valid_r   <= accept;
      pos_r        <= pos_nxt;
      out_valid_r  <= rd_en;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
    row_end_r <= (pos_r == ADDR_W'(ROW_LENGTH - 1));
  end

  // split the registered bank reads into colour planes
  always_comb begin
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
      out_item.red_lines[ch]   = bank_rdata[ch][0];
      out_item.green_lines[ch] = bank_rdata[ch][1];
      out_item.blue_lines[ch]  = bank_rdata[ch][2];
    end
    out_item.row_end = row_end_r;
  end

  assign out_valid = out_valid_r;

  // no result can appear while the store is being cleared
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !out_valid_r)
    else $error("result strobe during clearing pass");

  // a shift transfer gives a result after the request and bank read registers
  a_shift_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.req_type == REQ_SHIFT) |-> ##2 out_valid)
    else $error("shift transfer without result");

  // a write transfer never gives a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.req_type == REQ_WRITE) |-> ##2 !out_valid)
    else $error("write transfer produced a result");

  // the last position of a row leaves the shift position wrapped
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.row_end) |-> (pos_r == '0))
    else $error("shift position did not wrap after row end");

endmodule

@@ verif/tb_hub75_remap_frame_scanout.sv @@
// ----------------------------------------------------------------------------
// tb_hub75_remap_frame_scanout
// self-checking bench for the led panel frame store and scan-out
// ----------------------------------------------------------------------------
// A queue of requests is built at time zero. It holds a short directed part
// (panel corners, quadrant edges, odd sub-rows, coordinates off the panel,
// reads of cleared slots), then random writes and shifts. Some writes aim at
// the slot that the next shift reads. A clocked driver presents them with
// random gaps. Each accepted request goes through a local model of the
// remap and the store. A clocked monitor compares every result strobe with
// the oldest predicted scan vector.
// ----------------------------------------------------------------------------
module tb_hub75_remap_frame_scanout import hub75_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH    = CHANNEL_COUNT * ROW_LENGTH;
  localparam int IN_W           = $bits(in_item_t);
  localparam int RANDOM_ITEMS   = 1030;
  localparam int SETTLE_CYCLES  = 8;
  // longest correct quiet stretch: the clearing pass after reset, or a
  // long sender gap plus a short drain; taken several times over
  localparam int WATCHDOG_LIMIT = 2000;

  // one queued request plus its pacing
  typedef struct {
    in_item_t    item;
    int unsigned gap;          // idle cycles before it is presented
    bit          drain_first;  // hold off until every scan vector is back
  } pending_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  hub75_remap_frame_scanout dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // local copy of the panel store and the scan pointer
  logic [COLOR_W-1:0] frame_colors [STORE_DEPTH];
  logic [7:0]         scan_pos;

  // reverse map of the remap, used to aim writes at the next shift slot
  int unsigned slot_px   [STORE_DEPTH];
  int unsigned slot_py   [STORE_DEPTH];
  bit          slot_used [STORE_DEPTH];

  pending_req_t req_q[$];
  out_item_t    scan_expect_q[$];

  int unsigned idle_run;
  int unsigned shift_xfers;
  int unsigned result_xfers;
  int unsigned stall_cycles;
  int unsigned mismatch_count;

  // generator state
  int unsigned gen_pos;
  int unsigned gen_items;
  int unsigned calm_left;

  initial begin
    forever #5 clk = ~clk;
  end

  // pixel (x, y) to panel shift slot
  function automatic int unsigned panel_slot(int unsigned x, int unsigned y);
    int unsigned qx, qy, band, grp_row, grp_col, grp_idx, col, sub, inner, quad;
    qx      = x % QUAD_W;
    qy      = y % QUAD_H;
    band    = qy / 4;
    grp_row = band + (band + 1) / 4;
    grp_col = qx / 4;
    // serpentine group order: odd group rows come first within each pair
    grp_idx = (1 - grp_row % 2) * GROUPS_PER_ROW + (grp_row / 2) * 2 * GROUPS_PER_ROW
            + grp_col % GROUPS_PER_ROW;
    col = qx % 4;
    sub = qy % 4;
    // sub-row 0 sits after sub-row 1; sub-rows 2 and 3 run right to left
    if (sub == 0) begin
      inner = col + 4;
    end else if (sub == 1) begin
      inner = col;
    end else begin
      inner = (3 - col) + sub * 4;
    end
    quad = (x >= QUAD_W ? 1 : 0) + (y >= QUAD_H ? 2 : 0);
    return inner + grp_idx * GROUP_SLOTS + quad * QUAD_SLOTS;
  endfunction

  // model one accepted transfer; a shift adds one expected scan vector
  task automatic apply_request(in_item_t req);
    out_item_t want;
    logic [COLOR_W-1:0] c;
    if (req.req_type == REQ_WRITE) begin
      // writes off the panel are dropped
      if (req.pixel_x < PANEL_W && req.pixel_y < PANEL_H) begin
        frame_colors[panel_slot(req.pixel_x, req.pixel_y)] = req.pixel_color;
      end
    end else begin
      want = '0;
      for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
        c = frame_colors[ch * ROW_LENGTH + scan_pos];
        want.red_lines[ch]   = c[0];
        want.green_lines[ch] = c[1];
        want.blue_lines[ch]  = c[2];
      end
      want.row_end = (scan_pos == ROW_LENGTH - 1);
      scan_pos = (scan_pos == ROW_LENGTH - 1) ? 8'd0 : scan_pos + 8'd1;
      scan_expect_q.push_back(want);
      shift_xfers++;
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // gap before the next request: mostly none or short, a few long,
  // with calm stretches of back-to-back transfers
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end else if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_item(logic req, int unsigned x, int unsigned y, int unsigned color,
                            bit drain);
    pending_req_t p;
    p.item.req_type    = req;
    p.item.pixel_x     = x[5:0];
    p.item.pixel_y     = y[4:0];
    p.item.pixel_color = color[2:0];
    p.gap              = pick_gap();
    p.drain_first      = drain;
    req_q.push_back(p);
    gen_items++;
    if (req == REQ_SHIFT) begin
      gen_pos = (gen_pos + 1) % ROW_LENGTH;
    end
  endtask

  // shift with random junk in the unused pixel fields
  task automatic queue_shift(bit drain);
    queue_item(REQ_SHIFT, $urandom_range(0, 63), $urandom_range(0, 31),
               $urandom_range(0, 7), drain);
  endtask

  // write aimed at the slot that the next shift reads on a random channel
  task automatic queue_aimed_write();
    int unsigned s;
    s = $urandom_range(0, CHANNEL_COUNT - 1) * ROW_LENGTH + gen_pos;
    if (slot_used[s]) begin
      queue_item(REQ_WRITE, slot_px[s], slot_py[s], $urandom_range(0, 7), 1'b0);
    end
  endtask

  // stimulus and end of run
  initial begin
    int unsigned r, directed_n;
    for (int s = 0; s < STORE_DEPTH; s++) begin
      frame_colors[s] = '0;
      slot_used[s]    = 1'b0;
    end
    scan_pos       = '0;
    shift_xfers    = 0;
    result_xfers   = 0;
    mismatch_count = 0;
    gen_pos        = 0;
    gen_items      = 0;
    calm_left      = 0;
    for (int unsigned y = 0; y < PANEL_H; y++) begin
      for (int unsigned x = 0; x < PANEL_W; x++) begin
        slot_px[panel_slot(x, y)]   = x;
        slot_py[panel_slot(x, y)]   = y;
        slot_used[panel_slot(x, y)] = 1'b1;
      end
    end

    // directed: cleared store, corners, quadrant edges, odd sub-rows
    queue_shift(1'b0);
    queue_item(REQ_WRITE, 0, 0, 7, 1'b0);
    queue_item(REQ_WRITE, 47, 0, 1, 1'b0);
    queue_item(REQ_WRITE, 0, 23, 2, 1'b0);
    queue_item(REQ_WRITE, 47, 23, 4, 1'b0);
    queue_item(REQ_WRITE, 23, 11, 5, 1'b0);
    queue_item(REQ_WRITE, 24, 12, 6, 1'b0);
    queue_item(REQ_WRITE, 13, 2, 3, 1'b0);
    queue_item(REQ_WRITE, 30, 19, 7, 1'b0);
    // off the panel in x, in y and in both, one with all bits of the fields set
    queue_item(REQ_WRITE, 48, 0, 7, 1'b0);
    queue_item(REQ_WRITE, 63, 31, 7, 1'b0);
    queue_item(REQ_WRITE, 0, 24, 7, 1'b0);
    queue_item(REQ_WRITE, 5, 31, 3, 1'b0);
    // write straight ahead of the shift that reads it
    queue_aimed_write();
    queue_shift(1'b0);
    queue_aimed_write();
    queue_aimed_write();
    queue_shift(1'b1);
    queue_item(REQ_WRITE, 0, 0, 0, 1'b0);
    queue_shift(1'b0);
    queue_shift(1'b0);
    directed_n = gen_items;

    // random part, opened by a full drain
    queue_shift(1'b1);
    while (gen_items < directed_n + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        queue_shift($urandom_range(0, 199) == 0);
      end else if (r < 50) begin
        queue_aimed_write();
        if ($urandom_range(0, 1) == 1) begin
          queue_item(REQ_WRITE, $urandom_range(0, PANEL_W - 1),
                     $urandom_range(0, PANEL_H - 1), $urandom_range(0, 7), 1'b0);
        end
        queue_shift(1'b0);
      end else if (r < 94) begin
        queue_item(REQ_WRITE, $urandom_range(0, PANEL_W - 1), $urandom_range(0, PANEL_H - 1),
                   $urandom_range(0, 7), $urandom_range(0, 199) == 0);
      end else if ($urandom_range(0, 1) == 1) begin
        queue_item(REQ_WRITE, $urandom_range(PANEL_W, 63), $urandom_range(0, 31),
                   $urandom_range(0, 7), 1'b0);
      end else begin
        queue_item(REQ_WRITE, $urandom_range(0, 63), $urandom_range(PANEL_H, 31),
                   $urandom_range(0, 7), 1'b0);
      end
    end

    // reset once, synchronous
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // every request transferred, then every scan vector back
    while (req_q.size() != 0 || start) @(negedge clk);
    while (scan_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("hub75_remap_frame_scanout test passed");
    end else begin
      $display("hub75_remap_frame_scanout test failed");
    end
    $finish;
  end

  // driver: one transfer per rising edge with start high and busy low
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      in_item  <= '0;
      idle_run <= 0;
    end else begin
      if (start && !busy) begin
        apply_request(in_item);
      end
      if (start && busy) begin
        // hold the offered request until busy drops
      end else if (req_q.size() == 0) begin
        start   <= 1'b0;
        in_item <= IN_W'($urandom);
      end else if (req_q[0].drain_first && shift_xfers != result_xfers) begin
        // wait for every scan vector still in flight
        start   <= 1'b0;
        in_item <= IN_W'($urandom);
      end else if (idle_run < req_q[0].gap) begin
        idle_run <= idle_run + 1;
        start    <= 1'b0;
        in_item  <= IN_W'($urandom);
      end else begin
        start    <= 1'b1;
        in_item  <= req_q[0].item;
        idle_run <= 0;
        void'(req_q.pop_front());
      end
    end
  end

  // monitor: the strobe cannot be held off, take it on every edge it is high
  always @(posedge clk) begin : scan_monitor
    out_item_t want;
    if (rst_n && out_valid) begin
      result_xfers <= result_xfers + 1;
      if (scan_expect_q.size() == 0) begin
        report_mismatch($sformatf("scan vector with nothing expected: %h", out_item));
      end else begin
        want = scan_expect_q.pop_front();
        if (out_item.red_lines !== want.red_lines) begin
          report_mismatch($sformatf("red_lines %h, expected %h",
                                    out_item.red_lines, want.red_lines));
        end
        if (out_item.green_lines !== want.green_lines) begin
          report_mismatch($sformatf("green_lines %h, expected %h",
                                    out_item.green_lines, want.green_lines));
        end
        if (out_item.blue_lines !== want.blue_lines) begin
          report_mismatch($sformatf("blue_lines %h, expected %h",
                                    out_item.blue_lines, want.blue_lines));
        end
        if (out_item.row_end !== want.row_end) begin
          report_mismatch($sformatf("row_end %b, expected %b",
                                    out_item.row_end, want.row_end));
        end
      end
    end
  end

  // watchdog: too many cycles without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("hub75_remap_frame_scanout test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
